// File: design/sorted_unique_set_core_macros.svh
// Assertion macros shared by the sorted set core.
`ifndef SORTED_UNIQUE_SET_CORE_MACROS_SVH
`define SORTED_UNIQUE_SET_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SUS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted set check failed");

// Next-cycle implication, checked only out of reset.
`define SUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted set check failed");

`endif

// File: design/sus_pkg.sv
// Types, codes and sizes shared by the sorted set core and its cells.
package sus_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ELEM_W   = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef logic signed [ELEM_W-1:0] t_elem;

    // Broadcast to every cell.
    typedef struct packed {
        logic  load;   // commit an insert this cycle
        t_elem value;  // probe / insert value
    } t_cell_ctl;

    // What a cell hands to its right neighbor and to the status logic.
    typedef struct packed {
        logic  after;  // empty, or holds a value above the probe
        logic  equal;  // holds the probe value
        t_elem data;
    } t_cell_out;

endpackage

// File: design/sus_cell.sv
// One slot of the sorted chain: compare against the probe, shift right on insert.
module sus_cell (
    input  logic               i_clk,
    input  logic               i_valid,      // slot index below the count
    input  sus_pkg::t_cell_ctl i_ctl,
    input  sus_pkg::t_cell_out i_prev,       // left neighbor
    output sus_pkg::t_cell_out o_cell
);
    import sus_pkg::*;

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        o_cell.after = !i_valid || (r_data > i_ctl.value);
        o_cell.equal = i_valid && (r_data == i_ctl.value);
        o_cell.data  = r_data;
    end

    // Take the left neighbor's value when it also moves right, else the new value.
    always_comb begin
        n_data = r_data;
        if (i_ctl.load && o_cell.after) begin
            n_data = i_prev.after ? i_prev.data : i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// File: design/sorted_unique_set_core.sv
// Sorted set core: a chain of compare-and-shift cells holding distinct signed values.
// Each accepted item's result is registered; one item is taken per cycle unless a
// result waits on a stalled sink. Every cell compares against the probe in parallel
// and an insert shifts the upper part of the chain right by one slot in that cycle.
// Reset (synchronous, active low) empties the set and drops any pending result;
// cell contents are left as they are and are never read before being written.
module sorted_unique_set_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic [4:0]           o_count
);
    import sus_pkg::*;

    `include "sorted_unique_set_core_macros.svh"

    // Element count and the registered result.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic             n_valid;
    logic [2:0]       r_status;
    logic [2:0]       n_status;
    logic [CNT_W-1:0] r_res_count;
    logic [CNT_W-1:0] n_res_count;

    logic             w_accept;
    logic             w_present;
    logic             w_full;
    logic             w_commit;
    logic [31:0]      w_count_ext;
    t_cell_ctl        w_ctl;
    t_cell_out        w_cell [CAPACITY];
    logic [CAPACITY-1:0] w_equal;

    // Hold the input while a result waits and the sink stalls; a result taken
    // in this cycle frees the register for the next item.
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_present = |w_equal;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_commit  = w_accept && (i_operation == OP_INSERT) && !w_present && !w_full;

    assign w_ctl.load  = w_commit;
    assign w_ctl.value = i_value;

    // Chain of cells: slot 0 holds the smallest value. Each cell hands its
    // value and its compare result to the right neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_out w_prev;
        if (g == 0) begin : g_head
            assign w_prev = '{after: 1'b0, equal: 1'b0, data: '0};
        end else begin : g_body
            assign w_prev = w_cell[g-1];
        end

        sus_cell u_cell (
            .i_clk   (i_clk),
            .i_valid (CNT_W'(g) < r_count),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .o_cell  (w_cell[g])
        );

        assign w_equal[g] = w_cell[g].equal;
    end

    // Work out the status and the next count.
    always_comb begin
        n_count  = r_count;
        n_status = ST_ABSENT;
        case (i_operation)
            OP_INSERT: begin
                if (w_present) begin
                    n_status = ST_PRESENT;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + 1'b1;
                end
            end
            OP_LOOKUP: begin
                n_status = w_present ? ST_FOUND : ST_ABSENT;
            end
            OP_CLEAR: begin
                n_status = ST_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_status = ST_ABSENT;
            end
        endcase
    end

    // Output register: load on accept, drop once taken.
    always_comb begin
        n_valid     = r_valid && i_stall;
        n_res_count = r_res_count;
        if (w_accept) begin
            n_valid     = 1'b1;
            n_res_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
        r_res_count <= n_res_count;
    end

    assign w_count_ext = 32'(r_res_count);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_count     = w_count_ext[4:0];

    // Checks on the set bookkeeping.
    `SUS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SUS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_accept && (i_operation == OP_CLEAR),
        (r_count == '0) && o_valid && (o_status == ST_CLEARED))
    `SUS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_commit,
        (r_count == $past(r_count) + 1'b1) && (o_status == ST_INSERTED))
    `SUS_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n,
        w_accept && w_full && !w_present && (i_operation == OP_INSERT),
        $stable(r_count) && (o_status == ST_FULL))

endmodule
